/* rtl/bfsd_pkg.sv */
// ----------------------------------------------------------------------------
// bfsd_pkg
// Shared widths, defaults and saturating arithmetic for the blocking flow
// shop departure core.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsd_pkg;

  localparam int MAX_MACHINES_DEF = 32;
  localparam int DATA_W           = 32;
  localparam int PROC_W           = 16;
  localparam int COUNT_W          = 6;
  localparam int INDEX_W          = 5;
  localparam int COUNT_MIN        = 2;
  localparam int COUNT_RESET      = 2;

  typedef logic [DATA_W-1:0] data_t;

  function automatic data_t sat_add(input data_t a, input data_t b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/blocking_flowshop_departure_core.sv */
// ----------------------------------------------------------------------------
// blocking_flowshop_departure_core
// Blocking flow shop departure recurrence, one machine per transfer, with the
// committed departure row held in a rotating chain of cells.
// ----------------------------------------------------------------------------
//   channel | signals                                   | direction
//   cfg     | cfg_we, cfg_wdata                         | in, no wait
//   in      | in_valid/in_ready, proc_time, first_job,  | in
//           | commit                                    |
//   out     | out_valid/out_ready, departure_time,      | out
//           | machine_index, job_done, sigma            |
//
// One transfer per cycle while in_ready is high; departure stage, then sigma stage.
// The row ring rotates one cell per transfer so the head always holds the
// current machine's entry. A count write in the middle of a job realigns the
// ring back to the first machine's entry, with in_ready low.
// Reset is synchronous; a stalled output still lets one more transfer in.
// ----------------------------------------------------------------------------
`default_nettype none

module blocking_flowshop_departure_core #(
  parameter int MAX_MACHINES = bfsd_pkg::MAX_MACHINES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bfsd_pkg::COUNT_W-1:0]  cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bfsd_pkg::PROC_W-1:0]   proc_time,
  input  wire logic                          first_job,
  input  wire logic                          commit,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bfsd_pkg::DATA_W-1:0]        departure_time,
  output logic [bfsd_pkg::INDEX_W-1:0]       machine_index,
  output logic                               job_done,
  output logic [bfsd_pkg::DATA_W-1:0]        sigma
);

  localparam int LEN_W = $clog2(MAX_MACHINES + 1);
  localparam int JW    = $clog2(MAX_MACHINES);
  localparam int EW    = (LEN_W > bfsd_pkg::COUNT_W) ? LEN_W : bfsd_pkg::COUNT_W;
  localparam int DW    = bfsd_pkg::DATA_W;

  logic [bfsd_pkg::COUNT_W-1:0] count;
  logic [LEN_W-1:0]             ring_len;
  logic [LEN_W-1:0]             align_left;
  logic [JW-1:0]                counter;
  bfsd_pkg::data_t              prior;
  bfsd_pkg::data_t              sig_acc;

  logic                         s1_valid;
  bfsd_pkg::data_t              s1_cand;
  logic [DW:0]                  s1_base;
  logic [JW-1:0]                s1_j;
  logic                         s1_last;

  bfsd_pkg::data_t              row [MAX_MACHINES];

  logic [EW-1:0]                count_ext;
  logic [EW-1:0]                eff_w;
  logic [LEN_W-1:0]             eff;
  logic [LEN_W-1:0]             len_use;
  logic                         aligning;
  logic                         in_accept;
  logic                         advance;
  logic                         shift;
  logic                         is_first_mc;
  logic                         last;
  bfsd_pkg::data_t              p_ext;
  bfsd_pkg::data_t              add_base;
  bfsd_pkg::data_t              sum;
  bfsd_pkg::data_t              cand;
  bfsd_pkg::data_t              wrap;
  logic [DW:0]                  sig_base;
  bfsd_pkg::data_t              term;
  bfsd_pkg::data_t              acc;
  logic [JW+4:0]                j_wide;

  assign count_ext = EW'(count);
  assign eff_w     = (count_ext < EW'(bfsd_pkg::COUNT_MIN)) ? EW'(bfsd_pkg::COUNT_MIN) :
                     (count_ext > EW'(MAX_MACHINES)) ? EW'(MAX_MACHINES) : count_ext;
  assign eff       = eff_w[LEN_W-1:0];
  assign aligning  = align_left != '0;
  assign len_use   = aligning ? ring_len : eff;

  assign advance   = !out_valid || out_ready;
  assign in_ready  = !aligning && (!s1_valid || advance);
  assign in_accept = in_valid && in_ready;
  assign shift     = in_accept || aligning;

  assign is_first_mc = counter == '0;
  assign last        = LEN_W'(counter) == (len_use - LEN_W'(1));
  assign p_ext       = DW'(proc_time);

  always_comb begin
    if (first_job) begin
      add_base = is_first_mc ? '0 : prior;
    end else begin
      add_base = is_first_mc ? row[0] : prior;
    end
    sum = bfsd_pkg::sat_add(add_base, p_ext);
    if (first_job || last) begin
      cand = sum;
    end else begin
      cand = (sum > row[1]) ? sum : row[1];
    end
    sig_base = first_job ? {1'b0, p_ext} : ({1'b0, row[0]} + {1'b0, p_ext});
    wrap     = (in_accept && commit) ? cand : row[0];
  end

  for (genvar k = 0; k < MAX_MACHINES; k++) begin : g_cell
    bfsd_pkg::data_t nxt;
    if (k == MAX_MACHINES - 1) begin : g_end
      assign nxt = wrap;
    end else begin : g_mid
      assign nxt = row[k+1];
    end
    bfsd_cell #(
      .INDEX (k),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .ring_len  (len_use),
      .from_next (nxt),
      .wrap      (wrap),
      .value     (row[k])
    );
  end

  always_comb begin
    term = ({1'b0, s1_cand} > s1_base) ? (s1_cand - s1_base[DW-1:0]) : '0;
    acc  = bfsd_pkg::sat_add((s1_j == '0) ? '0 : sig_acc, term);
  end

  assign j_wide = {5'b0, s1_j};

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= bfsd_pkg::COUNT_W'(bfsd_pkg::COUNT_RESET);
      ring_len   <= LEN_W'(bfsd_pkg::COUNT_RESET);
      align_left <= '0;
      counter    <= '0;
      prior      <= '0;
      sig_acc    <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      ring_len <= len_use;
      if (aligning) begin
        align_left <= align_left - LEN_W'(1);
      end
      if (cfg_we) begin
        count   <= cfg_wdata;
        counter <= '0;
        sig_acc <= '0;
        if (counter != '0) begin
          align_left <= len_use - LEN_W'(counter);
        end
      end else if (in_accept) begin
        counter <= last ? '0 : counter + JW'(1);
      end
      if (in_accept) begin
        prior <= cand;
      end
      if (s1_valid && advance && !cfg_we) begin
        sig_acc <= s1_last ? '0 : acc;
      end
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cand <= cand;
      s1_base <= sig_base;
      s1_j    <= counter;
      s1_last <= last;
    end
    if (s1_valid && advance) begin
      departure_time <= s1_cand;
      machine_index  <= j_wide[4:0];
      job_done       <= s1_last;
      sigma          <= s1_last ? acc : '0;
    end
  end

  a_ready_not_aligning: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !aligning)
    else $error("input taken during ring realignment");

  a_counter_in_ring: assert property (@(posedge clk) disable iff (rst)
    LEN_W'(counter) < len_use)
    else $error("machine counter outside active ring");

  a_sigma_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !job_done |-> sigma == '0)
    else $error("sigma nonzero on a non-final machine");

  a_done_resets_counter: assert property (@(posedge clk) disable iff (rst)
    in_accept && last && !cfg_we |=> counter == '0)
    else $error("counter not restarted after last machine");

endmodule

`default_nettype wire

/* rtl/bfsd_cell.sv */
// ----------------------------------------------------------------------------
// bfsd_cell
// One entry of the departure row ring. Shifts toward the head; the tail of
// the active ring takes the value written back from the head.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsd_cell #(
  parameter int INDEX = 0,
  parameter int LEN_W = 6
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     shift,
  input  wire logic [LEN_W-1:0]         ring_len,
  input  wire bfsd_pkg::data_t          from_next,
  input  wire bfsd_pkg::data_t          wrap,
  output bfsd_pkg::data_t               value
);

  logic in_ring;
  logic is_tail;

  assign in_ring = LEN_W'(INDEX) < ring_len;
  assign is_tail = LEN_W'(INDEX) == (ring_len - LEN_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift && in_ring) begin
      value <= is_tail ? wrap : from_next;
    end
  end

endmodule

`default_nettype wire
